// ===== hdl/weighted_prefix_sum_selector_assert.svh =====
// Assertion macros for the weighted prefix sum selector.
// No dependencies; included by the top level.
`ifndef WEIGHTED_PREFIX_SUM_SELECTOR_ASSERT_SVH
`define WEIGHTED_PREFIX_SUM_SELECTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define WPSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the cycle after
`define WPSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wpss_pkg.sv =====
// Package for the weighted prefix sum selector: opcodes, token type, saturation.
// No dependencies.
`timescale 1ns / 1ps

package wpss_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int IXW = 11;

  localparam logic [3:0] OPC_PUSH     = 4'd0;
  localparam logic [3:0] OPC_ADD      = 4'd1;
  localparam logic [3:0] OPC_REVERT   = 4'd2;
  localparam logic [3:0] OPC_CLR_ADJ  = 4'd3;
  localparam logic [3:0] OPC_FIND     = 4'd4;
  localparam logic [3:0] OPC_WEIGHT   = 4'd5;
  localparam logic [3:0] OPC_PREFIX   = 4'd6;
  localparam logic [3:0] OPC_TOTAL    = 4'd7;
  localparam logic [3:0] OPC_CLR_ALL  = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    TOP_NOP, TOP_PUSH, TOP_ADD, TOP_REV, TOP_CLR, TOP_FIND, TOP_WGT, TOP_PRE
  } tok_op_t;

  typedef struct packed {
    logic               vld;
    tok_op_t            op;
    logic [IXW-1:0]     idx;
    logic signed [41:0] d;
    logic [39:0]        query;
    logic [31:0]        w;
    logic               found;
    logic [IXW-1:0]     fidx;
    logic signed [40:0] value;
    logic [39:0]        pbase;
    logic signed [40:0] padj;
  } token_t;

  function automatic logic signed [43:0] zx40(input logic [39:0] v);
    return signed'({4'b0, v});
  endfunction

  function automatic logic signed [43:0] sx41(input logic signed [40:0] v);
    return 44'(v);
  endfunction

  function automatic logic signed [40:0] sat41(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sh0_FF_FFFF_FFFF;
    lo = -44'sh100_0000_0000;
    if (v > hi) return 41'(hi);
    if (v < lo) return 41'(lo);
    return 41'(v);
  endfunction

  function automatic logic [39:0] sat40u(input logic [40:0] v);
    return v[40] ? {40{1'b1}} : v[39:0];
  endfunction

endpackage

// ===== hdl/wpss_if.sv =====
// Stream interfaces for the input and result channels.
// Depends on nothing.
`timescale 1ns / 1ps

interface wpss_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         opcode;
  logic [6:0]         entry_index;
  logic [31:0]        new_weight;
  logic signed [32:0] weight_delta;
  logic [39:0]        query_sum;
  modport source (output valid, opcode, entry_index, new_weight, weight_delta, query_sum,
                  input ready);
  modport sink (input valid, opcode, entry_index, new_weight, weight_delta, query_sum,
                output ready);
endinterface

interface wpss_out_if;
  logic               valid;
  logic               ready;
  logic [6:0]         found_index;
  logic signed [40:0] result_value;
  logic [1:0]         status;
  modport source (output valid, found_index, result_value, status, input ready);
  modport sink (input valid, found_index, result_value, status, output ready);
endinterface

// ===== hdl/wpss_cell.sv =====
// One table entry: base and adjustment cumulative sums, plus token stage.
// Depends on wpss_pkg.
`timescale 1ns / 1ps

module wpss_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  wpss_pkg::token_t tok_i,
  output wpss_pkg::token_t tok_o
);

  localparam logic [wpss_pkg::IXW-1:0] JJ  = wpss_pkg::IXW'(CELL_IDX);
  localparam logic [wpss_pkg::IXW-1:0] JJ1 = wpss_pkg::IXW'(CELL_IDX + 1);

  logic [39:0]        base_r, base_nxt;
  logic signed [40:0] adj_r, adj_nxt;
  wpss_pkg::token_t   tok_r, tok_nxt;
  logic signed [40:0] eff, dd;
  logic signed [41:0] negd;

  always_comb begin
    eff  = wpss_pkg::sat41(wpss_pkg::zx40(base_r) + wpss_pkg::sx41(adj_r));
    dd   = wpss_pkg::sat41(wpss_pkg::sx41(adj_r) - wpss_pkg::sx41(tok_i.padj));
    negd = -42'(dd);
    base_nxt = base_r;
    adj_nxt  = adj_r;
    tok_nxt  = tok_i;
    tok_nxt.pbase = base_r;
    tok_nxt.padj  = adj_r;
    unique case (tok_i.op)
      wpss_pkg::TOP_PUSH: begin
        if (JJ == tok_i.idx)
          base_nxt = wpss_pkg::sat40u({1'b0, tok_i.pbase} + {9'b0, tok_i.w});
      end
      wpss_pkg::TOP_ADD: begin
        if (JJ >= tok_i.idx) adj_nxt = wpss_pkg::sat41(wpss_pkg::sx41(adj_r) + 44'(tok_i.d));
      end
      wpss_pkg::TOP_REV: begin
        if (JJ == tok_i.idx) begin
          adj_nxt = wpss_pkg::sat41(wpss_pkg::sx41(adj_r) + 44'(negd));
          tok_nxt.d     = negd;
          tok_nxt.value = dd;
        end else if (JJ > tok_i.idx) begin
          adj_nxt = wpss_pkg::sat41(wpss_pkg::sx41(adj_r) + 44'(tok_i.d));
        end
      end
      wpss_pkg::TOP_CLR: adj_nxt = '0;
      wpss_pkg::TOP_FIND: begin
        if (JJ < tok_i.idx && !tok_i.found &&
            wpss_pkg::sx41(eff) > wpss_pkg::zx40(tok_i.query)) begin
          tok_nxt.found = 1'b1;
          tok_nxt.fidx  = JJ;
        end
      end
      wpss_pkg::TOP_WGT: begin
        if (JJ == tok_i.idx)
          tok_nxt.value = wpss_pkg::sat41((wpss_pkg::zx40(base_r) - wpss_pkg::zx40(tok_i.pbase))
                        + (wpss_pkg::sx41(adj_r) - wpss_pkg::sx41(tok_i.padj)));
      end
      wpss_pkg::TOP_PRE: begin
        if (JJ1 == tok_i.idx) tok_nxt.value = eff;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_r     <= '0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      if (tok_i.vld) begin
        base_r <= base_nxt;
        adj_r  <= adj_nxt;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== hdl/weighted_prefix_sum_selector.sv =====
// Top level of the weighted prefix sum selector: command decode, cell chain, output register.
// Depends on wpss_pkg, wpss_if, wpss_cell and the assertion header.
//
//   channel  | dir | handshake       | payload
//   in_bus   | in  | valid / ready   | opcode, entry_index, new_weight, weight_delta, query_sum
//   out_bus  | out | valid / ready   | found_index, result_value, status
//
// Each item walks the chain once, one cell per cycle unless the output stalls: the input
// token register, then the token register of each cell in turn, then the output register.
// One item at a time; the next is taken once the result is in the output register. Reset
// clears adjustments and the count. A stalled output freezes the chain once a token waits at its end.
`timescale 1ns / 1ps

module weighted_prefix_sum_selector #(
  parameter int MAX_ENTRIES = wpss_pkg::MAX_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  wpss_in_if.sink    in_bus,
  wpss_out_if.source out_bus
);

  `include "weighted_prefix_sum_selector_assert.svh"

  localparam int IXW = wpss_pkg::IXW;
  localparam logic [IXW-1:0] MAXN = IXW'(MAX_ENTRIES);

  wpss_pkg::token_t tok_w [0:MAX_ENTRIES];
  wpss_pkg::token_t tok0_r, tok0_nxt;
  logic [IXW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             busy_r, out_valid_r;
  logic [6:0]       fidx_r;
  logic signed [40:0] val_r;
  logic [1:0]       ost_r;
  logic             adv, acc, done;
  logic [IXW-1:0]   ix;
  wpss_pkg::token_t tl;

  assign tl  = tok_w[MAX_ENTRIES];
  assign adv = !(tl.vld && out_valid_r && !out_bus.ready);
  assign acc = in_bus.valid && in_bus.ready;
  assign done = tl.vld && adv;
  assign in_bus.ready = !busy_r;
  assign ix = IXW'(in_bus.entry_index);

  always_comb begin
    tok0_nxt = '0;
    tok0_nxt.vld   = 1'b1;
    tok0_nxt.op    = wpss_pkg::TOP_NOP;
    tok0_nxt.idx   = ix;
    tok0_nxt.d     = 42'(in_bus.weight_delta);
    tok0_nxt.query = in_bus.query_sum;
    tok0_nxt.w     = in_bus.new_weight;
    cnt_nxt = cnt_r;
    st_nxt  = wpss_pkg::ST_OK;
    unique case (in_bus.opcode)
      wpss_pkg::OPC_PUSH: begin
        if (cnt_r >= MAXN) st_nxt = wpss_pkg::ST_FULL;
        else begin
          tok0_nxt.op  = wpss_pkg::TOP_PUSH;
          tok0_nxt.idx = cnt_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      wpss_pkg::OPC_ADD, wpss_pkg::OPC_REVERT, wpss_pkg::OPC_WEIGHT: begin
        if (ix >= cnt_r) st_nxt = wpss_pkg::ST_RANGE;
        else if (in_bus.opcode == wpss_pkg::OPC_ADD) tok0_nxt.op = wpss_pkg::TOP_ADD;
        else if (in_bus.opcode == wpss_pkg::OPC_REVERT) tok0_nxt.op = wpss_pkg::TOP_REV;
        else tok0_nxt.op = wpss_pkg::TOP_WGT;
      end
      wpss_pkg::OPC_CLR_ADJ: tok0_nxt.op = wpss_pkg::TOP_CLR;
      wpss_pkg::OPC_CLR_ALL: begin
        tok0_nxt.op = wpss_pkg::TOP_CLR;
        cnt_nxt = '0;
      end
      wpss_pkg::OPC_FIND: begin
        tok0_nxt.op  = wpss_pkg::TOP_FIND;
        tok0_nxt.idx = cnt_r;
      end
      wpss_pkg::OPC_PREFIX: begin
        if (ix > cnt_r) st_nxt = wpss_pkg::ST_RANGE;
        else tok0_nxt.op = wpss_pkg::TOP_PRE;
      end
      wpss_pkg::OPC_TOTAL: begin
        tok0_nxt.op  = wpss_pkg::TOP_PRE;
        tok0_nxt.idx = cnt_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.vld  <= 1'b0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        tok0_r <= tok0_nxt;
        cnt_r  <= cnt_nxt;
        st_r   <= st_nxt;
        busy_r <= 1'b1;
      end else if (adv) begin
        tok0_r.vld <= 1'b0;
      end
      if (done) begin
        out_valid_r <= 1'b1;
        busy_r      <= 1'b0;
        fidx_r <= (tl.op == wpss_pkg::TOP_FIND) ? 7'(tl.found ? tl.fidx : tl.idx) : 7'd0;
        val_r  <= tl.value;
        ost_r  <= st_r;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign tok_w[0] = tok0_r;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    wpss_cell #(.CELL_IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok_w[g]),
      .tok_o (tok_w[g+1])
    );
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.found_index  = fidx_r;
  assign out_bus.result_value = val_r;
  assign out_bus.status       = ost_r;

  `WPSS_ASSERT_NEXT(a_acc_busy, clk, rst_n, acc, busy_r && tok0_r.vld, "accept must start a walk")
  `WPSS_ASSERT_SAME(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= MAXN, "entry count above table size")
  `WPSS_ASSERT_SAME(a_tail_busy, clk, rst_n, tl.vld, busy_r, "token in chain while idle")
  `WPSS_ASSERT_NEXT(a_done_out, clk, rst_n, done, out_valid_r && !busy_r, "result not registered")

endmodule
